FILE: rtl/core/tvdm_pkg.sv
// Shared types and fixed widths for the triangle Voronoi dual metrics block.
// No dependencies; imported by every module under rtl/core.
package tvdm_pkg;

    localparam int COORD_W = 32;            // input coordinate width
    localparam int DIFF_W  = COORD_W + 1;   // vertex difference width
    localparam int DOT_W   = 2 * DIFF_W;    // unsigned squared length width
    localparam int SUM_W   = DOT_W + 1;     // signed dot product width
    localparam int PROD_W  = 2 * DOT_W;     // product of two dot products
    localparam int LEN_W   = 33;            // edge and coedge length width
    localparam int VOL_W   = 50;            // volume share width
    localparam int ROOT_W  = VOL_W;         // every root search runs this wide
    localparam int MUL_DIG = 4;             // multiplier digit bits per stage

    // pipeline control shared by all stage chains
    typedef struct packed {
        logic en;   // global advance
        logic vld;  // request valid entering the chain
    } t_ctl;

endpackage

FILE: rtl/core/triangle_voronoi_dual_metrics.sv
// Throughput: one triangle per cycle while o_stall is low. Depth, the same for any
// FRAC_BITS, is set by the 4-bit-digit multiplier chains (17 and 34 stages) and the
// 50-stage bitwise root search.
// Reset: synchronous, active low; clears every valid bit, payload registers keep data.
// Top level: edge lengths, coedge lengths and Voronoi shares of one triangle.
// Depends on tvdm_pkg, tvdm_mul and tvdm_root.
module triangle_voronoi_dual_metrics #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_ax,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_ay,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_az,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_bx,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_by_coord,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_bz,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_cx,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_cy,
    input  logic signed [tvdm_pkg::COORD_W-1:0] i_cz,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tvdm_pkg::LEN_W-1:0]          o_edge_len_ab,
    output logic [tvdm_pkg::LEN_W-1:0]          o_edge_len_bc,
    output logic [tvdm_pkg::LEN_W-1:0]          o_edge_len_ca,
    output logic [tvdm_pkg::LEN_W-1:0]          o_coedge_len_ab,
    output logic [tvdm_pkg::LEN_W-1:0]          o_coedge_len_bc,
    output logic [tvdm_pkg::LEN_W-1:0]          o_coedge_len_ca,
    output logic [tvdm_pkg::VOL_W-1:0]          o_vol_a,
    output logic [tvdm_pkg::VOL_W-1:0]          o_vol_b,
    output logic [tvdm_pkg::VOL_W-1:0]          o_vol_c,
    output logic                                o_degenerate
);
    import tvdm_pkg::*;

    localparam int V_W   = PROD_W + 1;              // sum of two products
    localparam int N_W   = 2 * V_W;                 // root search numerator
    localparam int KD_SH = 2 * FRAC_BITS + 6;       // volume denominator scale
    localparam int K_W   = PROD_W + KD_SH;
    localparam int L3_W  = 3 * DOT_W;
    localparam int S2_W  = 1 + PROD_W + L3_W;

    // first multiplier bank
    localparam int M_LALB = 0;
    localparam int M_DA2  = 1;
    localparam int M_DB2  = 2;
    localparam int M_DC2  = 3;
    localparam int M_PC   = 4;
    localparam int M_PB   = 5;
    localparam int M_PA   = 6;
    localparam int M1_N   = 7;
    // second multiplier bank
    localparam int Q_NAB  = 0;
    localparam int Q_NBC  = 1;
    localparam int Q_NCA  = 2;
    localparam int Q_VA   = 3;
    localparam int Q_VB   = 4;
    localparam int Q_VC   = 5;
    localparam int M2_N   = 6;
    // root searches
    localparam int S_EAB  = 0;
    localparam int S_EBC  = 1;
    localparam int S_ECA  = 2;
    localparam int S_CAB  = 3;
    localparam int S_CBC  = 4;
    localparam int S_CCA  = 5;
    localparam int S_VA   = 6;
    localparam int S_VB   = 7;
    localparam int S_VC   = 8;
    localparam int SR_N   = 9;

    function automatic logic [LEN_W-1:0] sat_len(input logic [ROOT_W-1:0] r);
        return (|r[ROOT_W-1:LEN_W]) ? {LEN_W{1'b1}} : r[LEN_W-1:0];
    endfunction

    logic   w_en;
    t_ctl   w_ctl1, w_ctl2, w_ctl3;
    logic   r_out_vld;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = r_out_vld && i_stall;
    assign o_valid = r_out_vld;

    // ---------------- stage 1: edge vectors
    logic signed [COORD_W-1:0] w_pa [3];
    logic signed [COORD_W-1:0] w_pb [3];
    logic signed [COORD_W-1:0] w_pc [3];
    logic                      r_v1;
    logic signed [DIFF_W-1:0]  r_ab [3];   // B - A
    logic signed [DIFF_W-1:0]  r_ac [3];   // C - A
    logic signed [DIFF_W-1:0]  r_bc [3];   // C - B
    logic signed [DIFF_W-1:0]  r_ba [3];   // A - B

    assign w_pa[0] = i_ax;
    assign w_pa[1] = i_ay;
    assign w_pa[2] = i_az;
    assign w_pb[0] = i_bx;
    assign w_pb[1] = i_by_coord;
    assign w_pb[2] = i_bz;
    assign w_pc[0] = i_cx;
    assign w_pc[1] = i_cy;
    assign w_pc[2] = i_cz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= DIFF_W'(w_pb[k]) - DIFF_W'(w_pa[k]);
                r_ac[k] <= DIFF_W'(w_pc[k]) - DIFF_W'(w_pa[k]);
                r_bc[k] <= DIFF_W'(w_pc[k]) - DIFF_W'(w_pb[k]);
                r_ba[k] <= DIFF_W'(w_pa[k]) - DIFF_W'(w_pb[k]);
            end
        end
    end

    // ---------------- stage 2: component products
    logic                     r_v2;
    logic signed [DOT_W-1:0]  r_q_aa [3];
    logic signed [DOT_W-1:0]  r_q_bb [3];
    logic signed [DOT_W-1:0]  r_q_cc [3];
    logic signed [DOT_W-1:0]  r_q_da [3];
    logic signed [DOT_W-1:0]  r_q_db [3];
    logic signed [DOT_W-1:0]  r_q_dc [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_q_aa[k] <= r_ab[k] * r_ab[k];
                r_q_bb[k] <= r_ac[k] * r_ac[k];
                r_q_cc[k] <= r_bc[k] * r_bc[k];
                r_q_da[k] <= r_ab[k] * r_ac[k];
                r_q_db[k] <= r_ba[k] * r_bc[k];
                r_q_dc[k] <= r_ac[k] * r_bc[k];
            end
        end
    end

    // ---------------- stage 3: dot products
    logic                     r_v3;
    logic signed [SUM_W-1:0]  n_la3, n_lb3, n_lc3;
    logic [DOT_W-1:0]         r_la3, r_lb3, r_lc3;
    logic signed [SUM_W-1:0]  r_da3, r_db3, r_dc3;

    always_comb begin
        n_la3 = SUM_W'(r_q_aa[0]) + SUM_W'(r_q_aa[1]) + SUM_W'(r_q_aa[2]);
        n_lb3 = SUM_W'(r_q_bb[0]) + SUM_W'(r_q_bb[1]) + SUM_W'(r_q_bb[2]);
        n_lc3 = SUM_W'(r_q_cc[0]) + SUM_W'(r_q_cc[1]) + SUM_W'(r_q_cc[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la3 <= n_la3[DOT_W-1:0];
            r_lb3 <= n_lb3[DOT_W-1:0];
            r_lc3 <= n_lc3[DOT_W-1:0];
            r_da3 <= SUM_W'(r_q_da[0]) + SUM_W'(r_q_da[1]) + SUM_W'(r_q_da[2]);
            r_db3 <= SUM_W'(r_q_db[0]) + SUM_W'(r_q_db[1]) + SUM_W'(r_q_db[2]);
            r_dc3 <= SUM_W'(r_q_dc[0]) + SUM_W'(r_q_dc[1]) + SUM_W'(r_q_dc[2]);
        end
    end

    // ---------------- stage 4: magnitudes of the dot products
    logic                     r_v4;
    logic [DOT_W-1:0]         r_la4, r_lb4, r_lc4;
    logic [DOT_W-1:0]         r_ma4, r_mb4, r_mc4;
    logic signed [SUM_W-1:0]  n_na, n_nb, n_nc;

    always_comb begin
        n_na = r_da3[SUM_W-1] ? -r_da3 : r_da3;
        n_nb = r_db3[SUM_W-1] ? -r_db3 : r_db3;
        n_nc = r_dc3[SUM_W-1] ? -r_dc3 : r_dc3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la4 <= r_la3;
            r_lb4 <= r_lb3;
            r_lc4 <= r_lc3;
            r_ma4 <= n_na[DOT_W-1:0];
            r_mb4 <= n_nb[DOT_W-1:0];
            r_mc4 <= n_nc[DOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // ---------------- first multiplier bank
    logic [DOT_W-1:0]  w_m1_a    [M1_N];
    logic [DOT_W-1:0]  w_m1_b    [M1_N];
    logic [L3_W-1:0]   w_m1_si   [M1_N];
    logic [PROD_W-1:0] w_m1_p    [M1_N];
    logic [L3_W-1:0]   w_m1_so   [M1_N];
    logic [M1_N-1:0]   w_m1_vld;

    assign w_m1_a[M_LALB] = r_la4;  assign w_m1_b[M_LALB] = r_lb4;
    assign w_m1_a[M_DA2]  = r_ma4;  assign w_m1_b[M_DA2]  = r_ma4;
    assign w_m1_a[M_DB2]  = r_mb4;  assign w_m1_b[M_DB2]  = r_mb4;
    assign w_m1_a[M_DC2]  = r_mc4;  assign w_m1_b[M_DC2]  = r_mc4;
    assign w_m1_a[M_PC]   = r_la4;  assign w_m1_b[M_PC]   = r_mc4;
    assign w_m1_a[M_PB]   = r_lb4;  assign w_m1_b[M_PB]   = r_mb4;
    assign w_m1_a[M_PA]   = r_lc4;  assign w_m1_b[M_PA]   = r_ma4;

    assign w_ctl1 = '{en: w_en, vld: r_v4};

    for (genvar i = 0; i < M1_N; i++) begin : g_m1
        assign w_m1_si[i] = (i == M_LALB) ? {r_la4, r_lb4, r_lc4} : '0;
        tvdm_mul #(
            .A_W (DOT_W),
            .B_W (DOT_W),
            .SW  (L3_W)
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl1),
            .i_a     (w_m1_a[i]),
            .i_b     (w_m1_b[i]),
            .i_side  (w_m1_si[i]),
            .o_vld   (w_m1_vld[i]),
            .o_p     (w_m1_p[i]),
            .o_side  (w_m1_so[i])
        );
    end

    // ---------------- stage 5: cross term and share numerators
    logic              r_v5;
    logic [PROD_W-1:0] n_k5;
    logic [PROD_W-1:0] r_k5;
    logic              r_deg5;
    logic [V_W-1:0]    r_va5, r_vb5, r_vc5;
    logic [PROD_W-1:0] r_da2, r_db2, r_dc2;
    logic [L3_W-1:0]   r_l5;

    // |a|^2 |b|^2 - (a.b)^2 = |a x b|^2, never negative
    assign n_k5 = w_m1_p[M_LALB] - w_m1_p[M_DA2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= &w_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k5   <= n_k5;
            r_deg5 <= (n_k5 == '0);
            r_va5  <= V_W'(w_m1_p[M_PC]) + V_W'(w_m1_p[M_PB]);
            r_vb5  <= V_W'(w_m1_p[M_PC]) + V_W'(w_m1_p[M_PA]);
            r_vc5  <= V_W'(w_m1_p[M_PA]) + V_W'(w_m1_p[M_PB]);
            r_da2  <= w_m1_p[M_DA2];
            r_db2  <= w_m1_p[M_DB2];
            r_dc2  <= w_m1_p[M_DC2];
            r_l5   <= w_m1_so[M_LALB];
        end
    end

    // ---------------- second multiplier bank
    logic [DOT_W-1:0]  w_la5, w_lb5, w_lc5;
    logic [V_W-1:0]    w_m2_a    [M2_N];
    logic [V_W-1:0]    w_m2_b    [M2_N];
    logic [S2_W-1:0]   w_m2_si   [M2_N];
    logic [N_W-1:0]    w_m2_p    [M2_N];
    logic [S2_W-1:0]   w_m2_so   [M2_N];
    logic [M2_N-1:0]   w_m2_vld;

    assign {w_la5, w_lb5, w_lc5} = r_l5;

    assign w_m2_a[Q_NAB] = V_W'(r_dc2);  assign w_m2_b[Q_NAB] = V_W'(w_la5);
    assign w_m2_a[Q_NBC] = V_W'(r_da2);  assign w_m2_b[Q_NBC] = V_W'(w_lc5);
    assign w_m2_a[Q_NCA] = V_W'(r_db2);  assign w_m2_b[Q_NCA] = V_W'(w_lb5);
    assign w_m2_a[Q_VA]  = r_va5;        assign w_m2_b[Q_VA]  = r_va5;
    assign w_m2_a[Q_VB]  = r_vb5;        assign w_m2_b[Q_VB]  = r_vb5;
    assign w_m2_a[Q_VC]  = r_vc5;        assign w_m2_b[Q_VC]  = r_vc5;

    assign w_ctl2 = '{en: w_en, vld: r_v5};

    for (genvar i = 0; i < M2_N; i++) begin : g_m2
        assign w_m2_si[i] = (i == Q_NAB) ? {r_deg5, r_k5, r_l5} : '0;
        tvdm_mul #(
            .A_W (V_W),
            .B_W (V_W),
            .SW  (S2_W)
        ) u_mul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl2),
            .i_a     (w_m2_a[i]),
            .i_b     (w_m2_b[i]),
            .i_side  (w_m2_si[i]),
            .o_vld   (w_m2_vld[i]),
            .o_p     (w_m2_p[i]),
            .o_side  (w_m2_so[i])
        );
    end

    // ---------------- root searches
    logic              w_deg6;
    logic [PROD_W-1:0] w_k6;
    logic [DOT_W-1:0]  w_la6, w_lb6, w_lc6;
    logic [N_W-1:0]    w_s_n    [SR_N];
    logic [K_W-1:0]    w_s_k    [SR_N];
    logic              w_s_si   [SR_N];
    logic [ROOT_W-1:0] w_s_r    [SR_N];
    logic              w_s_so   [SR_N];
    logic [SR_N-1:0]   w_s_vld;
    logic [K_W-1:0]    w_k4, w_kd;

    assign {w_deg6, w_k6, w_la6, w_lb6, w_lc6} = w_m2_so[Q_NAB];
    assign w_k4 = K_W'(w_k6) << 2;
    assign w_kd = K_W'(w_k6) << KD_SH;

    assign w_s_n[S_EAB] = N_W'(w_la6);      assign w_s_k[S_EAB] = K_W'(1);
    assign w_s_n[S_EBC] = N_W'(w_lc6);      assign w_s_k[S_EBC] = K_W'(1);
    assign w_s_n[S_ECA] = N_W'(w_lb6);      assign w_s_k[S_ECA] = K_W'(1);
    assign w_s_n[S_CAB] = w_m2_p[Q_NAB];    assign w_s_k[S_CAB] = w_k4;
    assign w_s_n[S_CBC] = w_m2_p[Q_NBC];    assign w_s_k[S_CBC] = w_k4;
    assign w_s_n[S_CCA] = w_m2_p[Q_NCA];    assign w_s_k[S_CCA] = w_k4;
    assign w_s_n[S_VA]  = w_m2_p[Q_VA];     assign w_s_k[S_VA]  = w_kd;
    assign w_s_n[S_VB]  = w_m2_p[Q_VB];     assign w_s_k[S_VB]  = w_kd;
    assign w_s_n[S_VC]  = w_m2_p[Q_VC];     assign w_s_k[S_VC]  = w_kd;

    assign w_ctl3 = '{en: w_en, vld: &w_m2_vld};

    for (genvar i = 0; i < SR_N; i++) begin : g_sr
        assign w_s_si[i] = (i == S_EAB) ? w_deg6 : 1'b0;
        tvdm_root #(
            .R   (ROOT_W),
            .N_W (N_W),
            .K_W (K_W),
            .SW  (1)
        ) u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl3),
            .i_n     (w_s_n[i]),
            .i_k     (w_s_k[i]),
            .i_side  (w_s_si[i]),
            .o_vld   (w_s_vld[i]),
            .o_r     (w_s_r[i]),
            .o_side  (w_s_so[i])
        );
    end

    // ---------------- output register
    logic w_deg7;
    assign w_deg7 = w_s_so[S_EAB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= &w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_degenerate    <= w_deg7;
            o_edge_len_ab   <= w_deg7 ? '0 : sat_len(w_s_r[S_EAB]);
            o_edge_len_bc   <= w_deg7 ? '0 : sat_len(w_s_r[S_EBC]);
            o_edge_len_ca   <= w_deg7 ? '0 : sat_len(w_s_r[S_ECA]);
            o_coedge_len_ab <= w_deg7 ? '0 : sat_len(w_s_r[S_CAB]);
            o_coedge_len_bc <= w_deg7 ? '0 : sat_len(w_s_r[S_CBC]);
            o_coedge_len_ca <= w_deg7 ? '0 : sat_len(w_s_r[S_CCA]);
            o_vol_a         <= w_deg7 ? '0 : w_s_r[S_VA];
            o_vol_b         <= w_deg7 ? '0 : w_s_r[S_VB];
            o_vol_c         <= w_deg7 ? '0 : w_s_r[S_VC];
        end
    end

`ifndef SYNTHESIS
    a_stall_needs_valid : assert property (@(posedge i_clk)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_degenerate_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_edge_len_ab == '0 && o_edge_len_bc == '0 &&
        o_edge_len_ca == '0 && o_coedge_len_ab == '0 && o_coedge_len_bc == '0 &&
        o_coedge_len_ca == '0 && o_vol_a == '0 && o_vol_b == '0 && o_vol_c == '0))
        else $error("degenerate triangle with nonzero metrics");

    a_edges_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |-> (o_edge_len_ab != '0 && o_edge_len_bc != '0 &&
        o_edge_len_ca != '0))
        else $error("proper triangle with a zero edge");

    a_triangle_ineq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |-> ((LEN_W + 2)'(o_edge_len_ab) <=
        (LEN_W + 2)'(o_edge_len_bc) + (LEN_W + 2)'(o_edge_len_ca) + (LEN_W + 2)'(1)))
        else $error("edge lengths break the triangle inequality");
`endif

endmodule

FILE: rtl/core/tvdm_mul.sv
// Pipelined unsigned multiplier, one MUL_DIG-bit digit of i_b per stage.
// Depends on tvdm_pkg; carries a side payload and valid bit along with the data.
module tvdm_mul #(
    parameter int A_W = 66,
    parameter int B_W = 66,
    parameter int SW  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tvdm_pkg::t_ctl       i_ctl,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    input  logic [SW-1:0]        i_side,
    output logic                 o_vld,
    output logic [A_W+B_W-1:0]   o_p,
    output logic [SW-1:0]        o_side
);
    import tvdm_pkg::*;

    localparam int DIG = MUL_DIG;
    localparam int ST  = (B_W + DIG - 1) / DIG;
    localparam int BP  = ST * DIG;
    localparam int P_W = A_W + B_W;

    logic           r_vld  [ST];
    logic [A_W-1:0] r_a    [ST];
    logic [BP-1:0]  r_b    [ST];
    logic [P_W-1:0] r_acc  [ST];
    logic [SW-1:0]  r_side [ST];

    for (genvar s = 0; s < ST; s++) begin : g_st
        logic           vld_cur;
        logic [A_W-1:0] a_cur;
        logic [BP-1:0]  b_cur;
        logic [P_W-1:0] acc_cur;
        logic [SW-1:0]  side_cur;
        logic [P_W-1:0] a_ext;
        logic [P_W-1:0] n_acc;

        if (s == 0) begin : g_head
            assign vld_cur  = i_ctl.vld;
            assign a_cur    = i_a;
            assign b_cur    = BP'(i_b);
            assign acc_cur  = '0;
            assign side_cur = i_side;
        end else begin : g_body
            assign vld_cur  = r_vld[s-1];
            assign a_cur    = r_a[s-1];
            assign b_cur    = r_b[s-1];
            assign acc_cur  = r_acc[s-1];
            assign side_cur = r_side[s-1];
        end

        assign a_ext = P_W'(a_cur);
        assign n_acc = acc_cur + ((a_ext * P_W'(b_cur[s*DIG +: DIG])) << (s * DIG));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= vld_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_a[s]    <= a_cur;
                r_b[s]    <= b_cur;
                r_acc[s]  <= n_acc;
                r_side[s] <= side_cur;
            end
        end
    end

    assign o_vld  = r_vld[ST-1];
    assign o_p    = r_acc[ST-1];
    assign o_side = r_side[ST-1];

endmodule

FILE: rtl/core/tvdm_root.sv
// Pipelined search for the largest r below 2^R with r*r*k <= n, one bit per stage.
// Depends on tvdm_pkg; r*r*k and r*k are kept incrementally so each stage is adds only.
module tvdm_root #(
    parameter int R   = 50,
    parameter int N_W = 266,
    parameter int K_W = 170,
    parameter int SW  = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tvdm_pkg::t_ctl  i_ctl,
    input  logic [N_W-1:0]  i_n,
    input  logic [K_W-1:0]  i_k,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [R-1:0]    o_r,
    output logic [SW-1:0]   o_side
);
    import tvdm_pkg::*;

    localparam int TW0 = K_W + 2 * R;
    localparam int TW  = (TW0 > N_W) ? TW0 : N_W;
    localparam int UW  = K_W + R;

    logic           r_vld  [R];
    logic [TW-1:0]  r_t    [R];
    logic [UW-1:0]  r_u    [R];
    logic [R-1:0]   r_r    [R];
    logic [N_W-1:0] r_n    [R];
    logic [K_W-1:0] r_k    [R];
    logic [SW-1:0]  r_side [R];

    for (genvar s = 0; s < R; s++) begin : g_st
        localparam int BIT = R - 1 - s;
        logic           vld_cur;
        logic [TW-1:0]  t_cur;
        logic [UW-1:0]  u_cur;
        logic [R-1:0]   r_cur;
        logic [N_W-1:0] n_cur;
        logic [K_W-1:0] k_cur;
        logic [SW-1:0]  side_cur;
        logic [TW-1:0]  t_try;
        logic [UW-1:0]  u_try;
        logic           take;

        if (s == 0) begin : g_head
            assign vld_cur  = i_ctl.vld;
            assign t_cur    = '0;
            assign u_cur    = '0;
            assign r_cur    = '0;
            assign n_cur    = i_n;
            assign k_cur    = i_k;
            assign side_cur = i_side;
        end else begin : g_body
            assign vld_cur  = r_vld[s-1];
            assign t_cur    = r_t[s-1];
            assign u_cur    = r_u[s-1];
            assign r_cur    = r_r[s-1];
            assign n_cur    = r_n[s-1];
            assign k_cur    = r_k[s-1];
            assign side_cur = r_side[s-1];
        end

        // (r + 2^b)^2 k = r^2 k + 2^(b+1) r k + 2^(2b) k
        assign t_try = t_cur + (TW'(u_cur) << (BIT + 1)) + (TW'(k_cur) << (2 * BIT));
        assign u_try = u_cur + (UW'(k_cur) << BIT);
        assign take  = (t_try <= TW'(n_cur));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= vld_cur;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_t[s]    <= take ? t_try : t_cur;
                r_u[s]    <= take ? u_try : u_cur;
                r_r[s]    <= take ? (r_cur | (R'(1) << BIT)) : r_cur;
                r_n[s]    <= n_cur;
                r_k[s]    <= k_cur;
                r_side[s] <= side_cur;
            end
        end
    end

    assign o_vld  = r_vld[R-1];
    assign o_r    = r_r[R-1];
    assign o_side = r_side[R-1];

endmodule
